// ----- hdl/srg_pkg.sv -----
package srg_pkg;

	// Defaults for the top-level parameters.
	localparam int STEP_COUNT_BITS_DEF = 24;
	localparam int DELAY_BITS_DEF      = 16;
	localparam int PULSE_TICKS_DEF     = 10;

	// Configuration port geometry.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CHECK_W    = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd4;

	// Register values after reset.
	localparam logic [CFG_DATA_W-1:0] MAX_DELAY_RST      = 16'd2000;
	localparam logic [CFG_DATA_W-1:0] MIN_DELAY_RST      = 16'd500;
	localparam logic [CFG_DATA_W-1:0] ACCEL_RATE_RST     = 16'd10;
	localparam logic [CFG_DATA_W-1:0] DECEL_RATE_RST     = 16'd10;
	localparam logic [CHECK_W-1:0]    CHECK_INTERVAL_RST = 16'd10;

	// Shortest acceleration or braking ramp before the overlap fix.
	localparam int MIN_RAMP = 10;

	// Reason a move ended early.
	typedef enum logic [1:0] {
		CAUSE_NONE  = 2'd0,
		CAUSE_LIMIT = 2'd1,
		CAUSE_HALT  = 2'd2
	} abort_cause_t;

endpackage

// ----- hdl/srg_if.sv -----
// Tick channel: one word per microsecond tick.
interface srg_tick_if #(
	parameter int STEP_COUNT_BITS = srg_pkg::STEP_COUNT_BITS_DEF
);
	import srg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       start_move;
	logic [STEP_COUNT_BITS-1:0] step_total;
	logic                       move_direction;
	logic                       limit_hit;
	logic                       stop_request;
	logic                       alarm_critical;

	modport source (
		output valid, start_move, step_total, move_direction,
		       limit_hit, stop_request, alarm_critical,
		input  ready
	);
	modport sink (
		input  valid, start_move, step_total, move_direction,
		       limit_hit, stop_request, alarm_critical,
		output ready
	);
endinterface

// Result channel: one word per tick.
interface srg_result_if #(
	parameter int DELAY_BITS = srg_pkg::DELAY_BITS_DEF
);
	import srg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  step_pulse;
	logic                  dir_level;
	logic                  busy_res;
	logic                  move_done;
	logic                  move_aborted;
	abort_cause_t          abort_cause;
	logic [DELAY_BITS-1:0] step_period;

	modport source (
		output valid, step_pulse, dir_level, busy_res, move_done,
		       move_aborted, abort_cause, step_period,
		input  ready
	);
	modport sink (
		input  valid, step_pulse, dir_level, busy_res, move_done,
		       move_aborted, abort_cause, step_period,
		output ready
	);
endinterface

// ----- hdl/stepper_trapezoid_ramp_gen.sv -----
// An accepted tick word passes the input, divide and state stage registers on its way to its result word.
// Throughput: one tick word per cycle unless result.ready stalls; the output register and
// per-stage valids let a new word enter while a finished result still waits.
// The step-count split uses one reciprocal multiplier in the second stage.
// Reset (arst_n low, asynchronous) idles the axis, clears all counters and loads register defaults.
module stepper_trapezoid_ramp_gen #(
	parameter int STEP_COUNT_BITS = srg_pkg::STEP_COUNT_BITS_DEF,
	parameter int DELAY_BITS      = srg_pkg::DELAY_BITS_DEF,
	parameter int PULSE_TICKS     = srg_pkg::PULSE_TICKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	srg_tick_if.sink                      tick,
	srg_result_if.source                  result
);
	import srg_pkg::*;

	localparam int N  = STEP_COUNT_BITS;
	localparam int DB = DELAY_BITS;
	// Width for delay arithmetic: wide enough for delays and registers plus a carry.
	localparam int AW = ((DB > CFG_DATA_W) ? DB : CFG_DATA_W) + 1;
	// Rounded-up reciprocal of 5; the same constant gives exact /5 and /10.
	localparam logic [N:0]    RECIP5     = (N + 1)'((64'd1 << (N + 3)) / 64'd5 + 64'd1);
	localparam logic [DB:0]   PULSE_LEN  = (DB + 1)'(PULSE_TICKS);
	localparam logic [N-1:0]  MIN_RAMP_N = N'(MIN_RAMP);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ACCEL,
		PH_CRUISE,
		PH_BRAKE
	} phase_t;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] max_delay_q, min_delay_q, accel_rate_q, decel_rate_q;
	logic [CHECK_W-1:0]    check_interval_q;

	// Pipeline control.
	logic out_valid_q, s1_valid, s2_valid;
	logic out_free, s2_move, s2_free, s1_free, take;

	// Stage payloads.
	logic         s1_start, s1_dir, s1_limit, s1_stop, s1_alarm;
	logic [N-1:0] s1_total;
	logic         s2_start, s2_dir, s2_limit, s2_stop, s2_alarm;
	logic [N-1:0] s2_total, s2_q5, s2_q10;
	logic [2*N:0] recip_prod;

	// Axis state.
	phase_t          phase_q;
	logic [N-1:0]    left_q, cruise_q, brake_q;
	logic [DB-1:0]   delay_q, tick_q;
	logic [CHECK_W-1:0] check_cnt_q;
	logic            dir_q;

	// Registered result word.
	logic            pulse_q, busy_q, done_q, aborted_q;
	abort_cause_t    cause_q;
	logic [DB-1:0]   period_q;

	// Move plan.
	logic [N-1:0] acc_c, brk_c, acc_plan, brk_plan, cru_plan;
	logic [N:0]   ramp_sum;

	// Next-state logic.
	logic            start_go, running;
	phase_t          ph0, ph_n;
	logic [N-1:0]    left0, cru0, brk0, left_n;
	logic [DB-1:0]   delay0, tick0, delay_n, tick_n, period_n;
	logic [CHECK_W-1:0] cc0, cc_inc, cc_n;
	logic            dir0, pulse_n, done_n, abort_n;
	abort_cause_t    cause_n;
	logic [DB:0]     tick_inc, step_len, cur_len;
	logic [AW-1:0]   d_ext, mn_ext, mx_ext, brake_sum, ramp_delay;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q      <= MAX_DELAY_RST;
			min_delay_q      <= MIN_DELAY_RST;
			accel_rate_q     <= ACCEL_RATE_RST;
			decel_rate_q     <= DECEL_RATE_RST;
			check_interval_q <= CHECK_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_DELAY:      max_delay_q      <= cfg_wdata;
				REG_MIN_DELAY:      min_delay_q      <= cfg_wdata;
				REG_ACCEL_RATE:     accel_rate_q     <= cfg_wdata;
				REG_DECEL_RATE:     decel_rate_q     <= cfg_wdata;
				REG_CHECK_INTERVAL: check_interval_q <= CHECK_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Each stage moves on when the next one is empty or moving.
	assign out_free   = !out_valid_q || result.ready;
	assign s2_move    = s2_valid && out_free;
	assign s2_free    = !s2_valid || out_free;
	assign s1_free    = !s1_valid || s2_free;
	assign take       = tick.valid && s1_free;
	assign tick.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (s1_free) s1_valid <= tick.valid;
			if (s2_free) s2_valid <= s1_valid;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (take) begin
			s1_start <= tick.start_move;
			s1_total <= tick.step_total;
			s1_dir   <= tick.move_direction;
			s1_limit <= tick.limit_hit;
			s1_stop  <= tick.stop_request;
			s1_alarm <= tick.alarm_critical;
		end
	end

	// Divide the step count by 5 and by 10 through one reciprocal multiply.
	assign recip_prod = (2 * N + 1)'(s1_total) * (2 * N + 1)'(RECIP5);

	always_ff @(posedge clk) begin
		if (s1_free && s1_valid) begin
			s2_start <= s1_start;
			s2_total <= s1_total;
			s2_dir   <= s1_dir;
			s2_limit <= s1_limit;
			s2_stop  <= s1_stop;
			s2_alarm <= s1_alarm;
			s2_q5    <= N'(recip_prod >> (N + 3));
			s2_q10   <= N'(recip_prod >> (N + 4));
		end
	end

	// Split the move into ramps and cruise; overlapping ramps share the move half and half.
	always_comb begin
		acc_c    = (s2_q5 < MIN_RAMP_N) ? MIN_RAMP_N : s2_q5;
		brk_c    = (s2_q10 < MIN_RAMP_N) ? MIN_RAMP_N : s2_q10;
		ramp_sum = {1'b0, acc_c} + {1'b0, brk_c};
		if (ramp_sum > {1'b0, s2_total}) begin
			acc_plan = s2_total >> 1;
			brk_plan = s2_total - acc_plan;
			cru_plan = '0;
		end else begin
			acc_plan = acc_c;
			brk_plan = brk_c;
			cru_plan = s2_total - acc_c - brk_c;
		end
	end

	// Per-tick step sequencing, checks and pulse generation.
	always_comb begin
		start_go = (phase_q == PH_IDLE) && s2_start;
		if (start_go) begin
			ph0    = PH_ACCEL;
			left0  = acc_plan;
			cru0   = cru_plan;
			brk0   = brk_plan;
			delay0 = DB'(max_delay_q);
			tick0  = '0;
			cc0    = '0;
			dir0   = s2_dir;
		end else begin
			ph0    = phase_q;
			left0  = left_q;
			cru0   = cruise_q;
			brk0   = brake_q;
			delay0 = delay_q;
			tick0  = tick_q;
			cc0    = check_cnt_q;
			dir0   = dir_q;
		end

		ph_n     = ph0;
		left_n   = left0;
		tick_n   = tick0;
		cc_n     = cc0;
		cc_inc   = cc0 + CHECK_W'(1);
		pulse_n  = 1'b0;
		done_n   = 1'b0;
		abort_n  = 1'b0;
		cause_n  = CAUSE_NONE;
		period_n = '0;
		running  = 1'b0;
		tick_inc = {1'b0, tick0} + (DB + 1)'(1);
		step_len = ({1'b0, delay0} < PULSE_LEN) ? PULSE_LEN : {1'b0, delay0};

		if (ph0 != PH_IDLE) begin
			running = 1'b1;
			if (tick0 == '0) begin
				// Skip over phases that have no steps left.
				if (left0 == '0) begin
					unique case (ph0)
						PH_ACCEL: begin
							if (cru0 != '0) begin
								ph_n   = PH_CRUISE;
								left_n = cru0;
							end else if (brk0 != '0) begin
								ph_n   = PH_BRAKE;
								left_n = brk0;
							end else begin
								ph_n = PH_IDLE;
							end
						end
						PH_CRUISE: begin
							if (brk0 != '0) begin
								ph_n   = PH_BRAKE;
								left_n = brk0;
							end else begin
								ph_n = PH_IDLE;
							end
						end
						default: ph_n = PH_IDLE;
					endcase
				end
				if (ph_n == PH_IDLE) begin
					done_n  = 1'b1;
					running = 1'b0;
				end else begin
					// Stop and alarm are sampled every check_interval steps, limit every step.
					cc_n = cc_inc;
					if (cc_inc >= check_interval_q) begin
						if (s2_stop || s2_alarm) begin
							abort_n = 1'b1;
							cause_n = CAUSE_HALT;
						end else begin
							cc_n = '0;
						end
					end
					if (!abort_n && s2_limit) begin
						abort_n = 1'b1;
						cause_n = CAUSE_LIMIT;
					end
					if (abort_n) begin
						ph_n    = PH_IDLE;
						tick_n  = '0;
						running = 1'b0;
					end else begin
						left_n = left_n - N'(1);
					end
				end
			end
			if (running) begin
				pulse_n  = ({1'b0, tick0} < PULSE_LEN);
				period_n = delay0;
				if (tick_inc >= step_len) tick_n = '0;
				else tick_n = DB'(tick_inc);
			end
		end
	end

	// Period update at the end of a step, clamped at the configured limits.
	always_comb begin
		d_ext      = AW'(delay0);
		mn_ext     = AW'(min_delay_q);
		mx_ext     = AW'(max_delay_q);
		brake_sum  = d_ext + AW'(decel_rate_q);
		ramp_delay = d_ext;
		if (ph_n == PH_ACCEL) begin
			if (d_ext > mn_ext) begin
				if (AW'(accel_rate_q) >= d_ext - mn_ext) ramp_delay = mn_ext;
				else ramp_delay = d_ext - AW'(accel_rate_q);
			end
		end else if (ph_n == PH_BRAKE) begin
			if (d_ext < mx_ext) begin
				ramp_delay = (brake_sum > mx_ext) ? mx_ext : brake_sum;
			end
		end
		delay_n = (running && tick_inc >= step_len) ? DB'(ramp_delay) : delay0;
	end

	// Axis state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			left_q      <= '0;
			cruise_q    <= '0;
			brake_q     <= '0;
			delay_q     <= '0;
			tick_q      <= '0;
			check_cnt_q <= '0;
			dir_q       <= 1'b0;
			pulse_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			aborted_q   <= 1'b0;
			cause_q     <= CAUSE_NONE;
			period_q    <= '0;
		end else begin
			if (out_free) out_valid_q <= s2_valid;
			if (s2_move) begin
				phase_q     <= ph_n;
				left_q      <= left_n;
				cruise_q    <= cru0;
				brake_q     <= brk0;
				delay_q     <= delay_n;
				tick_q      <= tick_n;
				check_cnt_q <= cc_n;
				dir_q       <= dir0;
				pulse_q     <= pulse_n;
				busy_q      <= (ph_n != PH_IDLE);
				done_q      <= done_n;
				aborted_q   <= abort_n;
				cause_q     <= cause_n;
				period_q    <= period_n;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.step_pulse   = pulse_q;
	assign result.dir_level    = dir_q;
	assign result.busy_res     = busy_q;
	assign result.move_done    = done_q;
	assign result.move_aborted = aborted_q;
	assign result.abort_cause  = cause_q;
	assign result.step_period  = period_q;

	// Length of the step now running, for the checks below.
	assign cur_len = ({1'b0, delay_q} < PULSE_LEN) ? PULSE_LEN : {1'b0, delay_q};

	// A move cannot both finish and abort on one tick.
	a_done_abort_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(done_q && aborted_q))
		else $error("move_done and move_aborted both set");

	// An abort word carries a cause, and only an abort word does.
	a_cause_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (aborted_q == (cause_q != CAUSE_NONE)))
		else $error("abort_cause inconsistent with move_aborted");

	// An idle axis always restarts at the first tick of a step.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0))
		else $error("tick counter not cleared while idle");

	// The tick counter stays inside the current step.
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> ({1'b0, tick_q} < cur_len))
		else $error("tick counter ran past step length");

	// An idle axis never reports a running step.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !busy_q) |-> (!pulse_q && period_q == '0))
		else $error("step output while idle");

endmodule

// ----- tb/srg_axis_checker.sv -----
// Watches the configuration port and both channels, runs its own copy of the axis
// profile for every accepted tick word and compares each result word with the oldest
// word that copy produced.
module srg_axis_checker
	import srg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	srg_tick_if                   tick,
	srg_result_if                 result,
	output int                    mismatches,
	output int                    pending_words,
	output int                    words_checked,
	output int                    moves_done,
	output int                    limit_aborts,
	output int                    halt_aborts
);

	localparam int STEP_W = STEP_COUNT_BITS_DEF;
	localparam int DLY_W  = DELAY_BITS_DEF;
	localparam int PULSE  = PULSE_TICKS_DEF;

	typedef enum logic [1:0] {
		RP_IDLE,
		RP_ACCEL,
		RP_CRUISE,
		RP_BRAKE
	} ramp_phase_e;

	typedef struct {
		logic             start;
		logic [STEP_W-1:0] total;
		logic             dir;
		logic             limit;
		logic             stop;
		logic             alarm;
	} tick_word_t;

	typedef struct {
		logic             pulse;
		logic             dir;
		logic             busy;
		logic             done;
		logic             aborted;
		abort_cause_t     cause;
		logic [DLY_W-1:0] period;
	} axis_word_t;

	// Register copies.
	logic [DLY_W-1:0]   r_max;
	logic [DLY_W-1:0]   r_min;
	logic [DLY_W-1:0]   r_accel;
	logic [DLY_W-1:0]   r_decel;
	logic [CHECK_W-1:0] r_interval;

	// Axis state.
	ramp_phase_e        phase;
	logic [STEP_W-1:0]  steps_left;
	logic [STEP_W-1:0]  cruise_n;
	logic [STEP_W-1:0]  brake_n;
	logic [DLY_W-1:0]   delay;
	logic [DLY_W-1:0]   tick_n;
	logic [CHECK_W-1:0] chk_n;
	logic               dir_q;

	axis_word_t         axis_words[$];

	// Advances the axis by one tick and returns the word it shows for that tick.
	function automatic axis_word_t advance_axis(tick_word_t w);
		axis_word_t        o;
		logic [STEP_W:0]   tot;
		logic [STEP_W:0]   acc;
		logic [STEP_W:0]   brk;
		logic [DLY_W:0]    grown;
		int unsigned       len;
		logic              running;
		o.pulse   = 1'b0;
		o.done    = 1'b0;
		o.aborted = 1'b0;
		o.cause   = CAUSE_NONE;
		o.period  = '0;
		// A start is taken only while idle; the ramps are split and then clamped.
		if (phase == RP_IDLE && w.start) begin
			tot = {1'b0, w.total};
			acc = (STEP_W + 1)'(tot / 5);
			brk = (STEP_W + 1)'(tot / 10);
			if (acc < MIN_RAMP) acc = (STEP_W + 1)'(MIN_RAMP);
			if (brk < MIN_RAMP) brk = (STEP_W + 1)'(MIN_RAMP);
			if (acc + brk > tot) begin
				acc      = tot >> 1;
				brk      = tot - acc;
				cruise_n = '0;
			end else begin
				cruise_n = STEP_W'(tot - acc - brk);
			end
			brake_n    = brk[STEP_W-1:0];
			steps_left = acc[STEP_W-1:0];
			phase      = RP_ACCEL;
			delay      = r_max;
			tick_n     = '0;
			chk_n      = '0;
			dir_q      = w.dir;
		end
		if (phase != RP_IDLE) begin
			running = 1'b1;
			// Step boundary: skip empty phases, then run the halt and limit checks.
			if (tick_n == 0) begin
				while (phase != RP_IDLE && steps_left == 0) begin
					case (phase)
						RP_ACCEL: begin
							phase      = RP_CRUISE;
							steps_left = cruise_n;
						end
						RP_CRUISE: begin
							phase      = RP_BRAKE;
							steps_left = brake_n;
						end
						default: phase = RP_IDLE;
					endcase
				end
				if (phase == RP_IDLE) begin
					o.done  = 1'b1;
					running = 1'b0;
				end else begin
					chk_n = chk_n + 1'b1;
					if (chk_n >= r_interval) begin
						if (w.stop || w.alarm) begin
							o.aborted = 1'b1;
							o.cause   = CAUSE_HALT;
						end else begin
							chk_n = '0;
						end
					end
					if (!o.aborted && w.limit) begin
						o.aborted = 1'b1;
						o.cause   = CAUSE_LIMIT;
					end
					if (o.aborted) begin
						phase   = RP_IDLE;
						tick_n  = '0;
						running = 1'b0;
					end else begin
						steps_left = steps_left - 1'b1;
					end
				end
			end
			// Inside a step: pulse for the first ticks, then update the period at its end.
			if (running) begin
				len      = (delay < PULSE) ? PULSE : delay;
				o.pulse  = (tick_n < PULSE);
				o.period = delay;
				tick_n   = tick_n + 1'b1;
				if (tick_n >= len) begin
					case (phase)
						RP_ACCEL: begin
							if (delay > r_min) begin
								if (r_accel >= delay - r_min) delay = r_min;
								else delay = delay - r_accel;
							end
						end
						RP_BRAKE: begin
							if (delay < r_max) begin
								grown = delay + r_decel;
								delay = (grown > r_max) ? r_max : grown[DLY_W-1:0];
							end
						end
						default: ;
					endcase
					tick_n = '0;
				end
			end
		end
		o.dir  = dir_q;
		o.busy = (phase != RP_IDLE);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_word_t tw;
		axis_word_t got;
		axis_word_t want;
		if (!arst_n) begin
			r_max         = MAX_DELAY_RST;
			r_min         = MIN_DELAY_RST;
			r_accel       = ACCEL_RATE_RST;
			r_decel       = DECEL_RATE_RST;
			r_interval    = CHECK_INTERVAL_RST;
			phase         = RP_IDLE;
			steps_left    = '0;
			cruise_n      = '0;
			brake_n       = '0;
			delay         = '0;
			tick_n        = '0;
			chk_n         = '0;
			dir_q         = 1'b0;
			axis_words.delete();
			mismatches    = 0;
			pending_words = 0;
			words_checked = 0;
			moves_done    = 0;
			limit_aborts  = 0;
			halt_aborts   = 0;
		end else begin
			// Register writes are to be made only while no word is in flight; the checker does not enforce it.
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_DELAY:      r_max      = cfg_wdata;
					REG_MIN_DELAY:      r_min      = cfg_wdata;
					REG_ACCEL_RATE:     r_accel    = cfg_wdata;
					REG_DECEL_RATE:     r_decel    = cfg_wdata;
					REG_CHECK_INTERVAL: r_interval = cfg_wdata;
					default: ;
				endcase
			end
			// Result words are checked before this edge's tick word is added.
			if (result.valid && result.ready) begin
				got.pulse   = result.step_pulse;
				got.dir     = result.dir_level;
				got.busy    = result.busy_res;
				got.done    = result.move_done;
				got.aborted = result.move_aborted;
				got.cause   = result.abort_cause;
				got.period  = result.step_period;
				if (axis_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unrequested result word pulse=%0d dir=%0d busy=%0d",
							got.pulse, got.dir, got.busy);
				end else begin
					want = axis_words.pop_front();
					words_checked++;
					if (got.pulse !== want.pulse || got.dir !== want.dir ||
						got.busy !== want.busy || got.done !== want.done ||
						got.aborted !== want.aborted || got.cause !== want.cause ||
						got.period !== want.period) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: word %0d differs (pulse dir busy done aborted cause period)",
								words_checked);
							$display("  want %0d %0d %0d %0d %0d %0d %0d", want.pulse, want.dir,
								want.busy, want.done, want.aborted, want.cause, want.period);
							$display("  got  %0d %0d %0d %0d %0d %0d %0d", got.pulse, got.dir,
								got.busy, got.done, got.aborted, got.cause, got.period);
						end
					end
				end
			end
			if (tick.valid && tick.ready) begin
				tw.start = tick.start_move;
				tw.total = tick.step_total;
				tw.dir   = tick.move_direction;
				tw.limit = tick.limit_hit;
				tw.stop  = tick.stop_request;
				tw.alarm = tick.alarm_critical;
				want = advance_axis(tw);
				if (want.done) moves_done++;
				if (want.aborted && want.cause == CAUSE_LIMIT) limit_aborts++;
				if (want.aborted && want.cause == CAUSE_HALT) halt_aborts++;
				axis_words.push_back(want);
			end
			pending_words = axis_words.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	import srg_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;
	int settings_run;

	int mismatches;
	int pending_words;
	int words_checked;
	int moves_done;
	int limit_aborts;
	int halt_aborts;

	srg_tick_if   tick_ch ();
	srg_result_if result_ch ();

	stepper_trapezoid_ramp_gen DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.result    (result_ch)
	);

	srg_axis_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.tick          (tick_ch),
		.result        (result_ch),
		.mismatches    (mismatches),
		.pending_words (pending_words),
		.words_checked (words_checked),
		.moves_done    (moves_done),
		.limit_aborts  (limit_aborts),
		.halt_aborts   (halt_aborts)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d result words outstanding", pending_words);
			$display("Test completed with failures");
			$finish;
		end
	end

	// The result receiver stalls at random.
	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Presents one tick word after a random gap and holds it until it is taken.
	task automatic drive_tick(input logic go, input logic [STEP_COUNT_BITS_DEF-1:0] total,
		input logic dir, input logic lim, input logic stp, input logic alm);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tick_ch.valid = 1'b0;
			@(negedge clk);
		end
		tick_ch.valid          = 1'b1;
		tick_ch.start_move     = go;
		tick_ch.step_total     = total;
		tick_ch.move_direction = dir;
		tick_ch.limit_hit      = lim;
		tick_ch.stop_request   = stp;
		tick_ch.alarm_critical = alm;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits until every result word is back and the pipeline has drained.
	task automatic wait_idle();
		tick_ch.valid = 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] max_d, input logic [CFG_DATA_W-1:0] min_d,
		input logic [CFG_DATA_W-1:0] acc, input logic [CFG_DATA_W-1:0] dec,
		input logic [CFG_DATA_W-1:0] intv);
		logic [CFG_IDX_W-1:0]  idx[5];
		logic [CFG_DATA_W-1:0] val[5];
		idx = '{REG_MAX_DELAY, REG_MIN_DELAY, REG_ACCEL_RATE, REG_DECEL_RATE, REG_CHECK_INTERVAL};
		val = '{max_d, min_d, acc, dec, intv};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en = 1'b1;
			cfg_index = idx[i];
			cfg_wdata = val[i];
			@(negedge clk);
		end
		cfg_wr_en = 1'b0;
		settings_run++;
	endtask

	// Mostly short moves, with an occasional full-range count that a check cuts short.
	function automatic logic [STEP_COUNT_BITS_DEF-1:0] pick_total();
		case ($urandom_range(0, 15))
			0:       return STEP_COUNT_BITS_DEF'($urandom());
			1, 2:    return STEP_COUNT_BITS_DEF'($urandom_range(0, 19));
			default: return STEP_COUNT_BITS_DEF'($urandom_range(20, 60));
		endcase
	endfunction

	// Random ticks: occasional starts (ignored while moving), sparse limit, stop and alarm.
	task automatic random_ticks(input int count);
		repeat (count)
			drive_tick($urandom_range(0, 9) == 0, pick_total(), $urandom_range(0, 1) == 1,
				$urandom_range(0, 39) == 0, $urandom_range(0, 19) == 0,
				$urandom_range(0, 19) == 0);
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = REG_MAX_DELAY;
		cfg_wdata              = '0;
		tick_ch.valid          = 1'b0;
		tick_ch.start_move     = 1'b0;
		tick_ch.step_total     = '0;
		tick_ch.move_direction = 1'b0;
		tick_ch.limit_hit      = 1'b0;
		tick_ch.stop_request   = 1'b0;
		tick_ch.alarm_critical = 1'b0;
		send_idle_pct          = 32;
		recv_stall_pct         = 80;
		cycle_count            = 0;
		settings_run           = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values: an idle tick, a zero-step move, and a limit hit on the first step.
		drive_tick(1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		drive_tick(1'b1, '0, 1'b1, 1'b0, 1'b0, 1'b0);
		drive_tick(1'b1, 24'hFFFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
		wait_idle();

		// Checks on every step: halt on stop, halt winning over limit, a one-step move
		// with a start arriving while it runs.
		write_regs(16'd20, 16'd12, 16'd3, 16'd4, 16'd1);
		drive_tick(1'b1, 24'hFFFFFF, 1'b1, 1'b0, 1'b1, 1'b0);
		drive_tick(1'b1, 24'd5, 1'b0, 1'b1, 1'b0, 1'b1);
		drive_tick(1'b1, 24'd1, 1'b0, 1'b0, 1'b0, 1'b0);
		drive_tick(1'b1, 24'd9, 1'b1, 1'b0, 1'b0, 1'b0);
		repeat (19) drive_tick(1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		wait_idle();

		// Random moves over several register settings and idle patterns.
		write_regs(16'd24, 16'd12, 16'd2, 16'd3, 16'd3);
		random_ticks(230);
		wait_idle();
		write_regs(16'd11, 16'd11, 16'd0, 16'd0, 16'd1);
		random_ticks(230);
		wait_idle();
		send_idle_pct  = 80;
		recv_stall_pct = 32;
		write_regs(16'd40, 16'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_ticks(230);
		wait_idle();
		write_regs(16'd13, 16'd30, 16'd5, 16'd1, 16'd2);
		random_ticks(230);
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_regs(16'd100, 16'd11, 16'd7, 16'd9, 16'd4);
		random_ticks(230);
		wait_idle();

		// Full-scale rates: one ramp step jumps to the floor, the next brake step saturates.
		write_regs(16'd60, 16'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		drive_tick(1'b1, 24'd3, 1'b1, 1'b0, 1'b0, 1'b0);
		repeat (60 + 11 + 60 + 4) drive_tick(1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		wait_idle();

		$display("Checked %0d tick words over %0d register settings plus reset values.",
			words_checked, settings_run);
		$display("Moves: %0d completed, %0d stopped by the limit, %0d by stop or alarm.",
			moves_done, limit_aborts, halt_aborts);
		if (mismatches == 0 && pending_words == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
